>>> src/linear_probe_hash_map_unit_defines.svh
// ----------------------------------------------------------------------------
// linear_probe_hash_map_unit_defines
// assertion macros shared by the checker
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_MAP_UNIT_DEFINES_SVH
`define LINEAR_PROBE_HASH_MAP_UNIT_DEFINES_SVH

// same-cycle implication
`define LPHM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LPHM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/lphm_pkg.sv
// ----------------------------------------------------------------------------
// lphm_pkg
// types and codes shared by the hash map controller, datapath and top level
// ----------------------------------------------------------------------------
package lphm_pkg;

    localparam logic [1:0] REQ_GET     = 2'd0;
    localparam logic [1:0] REQ_GET_DEF = 2'd1;
    localparam logic [1:0] REQ_PUT     = 2'd2;
    localparam logic [1:0] REQ_DEL     = 2'd3;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] key;
        logic [31:0] hash_word;
        logic [31:0] value;
        logic [31:0] fallback_value;
    } req_t;

    typedef struct packed {
        logic        found;
        logic [31:0] read_value;
        logic        status;
        logic [8:0]  entry_total;
    } rsp_t;

    typedef enum logic [2:0] {
        RD_HOLD      = 3'd0,
        RD_HOME_REQ  = 3'd1,
        RD_CUR_NEXT  = 3'd2,
        RD_SLOT_NEXT = 3'd3,
        RD_SCAN_NEXT = 3'd4,
        RD_MOVE_HOME = 3'd5
    } rd_sel_t;

    typedef enum logic [2:0] {
        WR_NONE     = 3'd0,
        WR_CLEAR    = 3'd1,
        WR_REQ      = 3'd2,
        WR_DEL      = 3'd3,
        WR_SCAN_CLR = 3'd4,
        WR_MOVE     = 3'd5
    } wr_sel_t;

    typedef struct packed {
        logic    load_req;
        rd_sel_t rd_sel;
        wr_sel_t wr_sel;
        logic    probe_start;
        logic    probe_adv;
        logic    probe_stop;
        logic    iter_clr;
        logic    iter_inc;
        logic    mv_load;
        logic    finish;
        logic    clr_inc;
    } cmd_t;

    typedef struct packed {
        logic       clr_last;
        logic       mod_done;
        logic       rd_empty;
        logic       rd_match;
        logic       rd_at_home;
        logic       probe_last;
        logic       iter_last;
        logic       hit;
        logic       none;
        logic [1:0] req_type;
        logic       count_gt1;
    } sts_t;

endpackage

>>> src/linear_probe_hash_map_unit.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_map_unit
// open-addressed key/value table with linear probing and cluster repair
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Its result shows on
// rsp for one cycle with done high and must be taken then. After reset the
// unit sweeps the slot memory with busy high, clearing every slot. A request
// then finds its home slot, over 16-bit chunks of HASH_WIDTH when CAPACITY
// is not a power of two, and probes slots from there, one memory read per
// cycle. A delete that hits while more than one entry is stored keeps busy
// high after done while it walks the rest of the cluster, reading each slot
// scanned and probing from home for each entry it moves.
module linear_probe_hash_map_unit
    import lphm_pkg::*;
#(
    parameter int CAPACITY    = 256,
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32,
    parameter int HASH_WIDTH  = 32
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  req_t req,
    output logic busy,
    output logic done,
    output rsp_t rsp
);

    cmd_t cmd;
    sts_t sts;

    lphm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    lphm_dp #(
        .CAPACITY    (CAPACITY),
        .KEY_WIDTH   (KEY_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH),
        .HASH_WIDTH  (HASH_WIDTH)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .sts   (sts),
        .rsp   (rsp),
        .done  (done)
    );

endmodule

>>> src/lphm_ctrl.sv
// ----------------------------------------------------------------------------
// lphm_ctrl
// sequencer for clearing, probing, request handling and cluster repair
// ----------------------------------------------------------------------------
module lphm_ctrl
    import lphm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  sts_t sts,
    output cmd_t cmd,
    output logic busy
);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b000_0001,
        S_IDLE  = 7'b000_0010,
        S_MOD   = 7'b000_0100,
        S_PROBE = 7'b000_1000,
        S_ACT   = 7'b001_0000,
        S_SCAN  = 7'b010_0000,
        S_MOVE  = 7'b100_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        cmd.rd_sel = RD_HOLD;
        cmd.wr_sel = WR_NONE;
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.wr_sel  = WR_CLEAR;
                cmd.clr_inc = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_MOD;
                end
            end
            S_MOD:
            begin
                if (sts.mod_done)
                begin
                    cmd.rd_sel      = RD_HOME_REQ;
                    cmd.probe_start = 1'b1;
                    state_next      = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (sts.rd_empty || sts.rd_match || sts.probe_last)
                begin
                    cmd.probe_stop = 1'b1;
                    state_next     = S_ACT;
                end
                else
                begin
                    // fetch the next slot ahead of the decision on it
                    cmd.rd_sel    = RD_CUR_NEXT;
                    cmd.probe_adv = 1'b1;
                end
            end
            S_ACT:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
                case (sts.req_type)
                    REQ_PUT:
                    begin
                        if (!sts.none)
                        begin
                            cmd.wr_sel = WR_REQ;
                        end
                    end
                    REQ_DEL:
                    begin
                        if (sts.hit)
                        begin
                            cmd.wr_sel = WR_DEL;
                            if (sts.count_gt1)
                            begin
                                cmd.rd_sel   = RD_SLOT_NEXT;
                                cmd.iter_clr = 1'b1;
                                state_next   = S_SCAN;
                            end
                        end
                    end
                    default:
                    begin
                        cmd.wr_sel = WR_NONE;
                    end
                endcase
            end
            S_SCAN:
            begin
                if (sts.rd_empty)
                begin
                    state_next = S_IDLE;
                end
                else if (sts.rd_at_home)
                begin
                    if (sts.iter_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.rd_sel   = RD_SCAN_NEXT;
                        cmd.iter_inc = 1'b1;
                    end
                end
                else
                begin
                    // lift the entry out and look for its new place from home
                    cmd.mv_load = 1'b1;
                    cmd.wr_sel  = WR_SCAN_CLR;
                    cmd.rd_sel  = RD_MOVE_HOME;
                    state_next  = S_MOVE;
                end
            end
            S_MOVE:
            begin
                if (sts.rd_empty)
                begin
                    cmd.wr_sel = WR_MOVE;
                    if (sts.iter_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.rd_sel   = RD_SCAN_NEXT;
                        cmd.iter_inc = 1'b1;
                        state_next   = S_SCAN;
                    end
                end
                else
                begin
                    cmd.rd_sel = RD_CUR_NEXT;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> src/lphm_dp.sv
// ----------------------------------------------------------------------------
// lphm_dp
// slot memory, request registers, home slot unit, probe pointers and result
// ----------------------------------------------------------------------------
module lphm_dp
    import lphm_pkg::*;
#(
    parameter int CAPACITY    = 256,
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32,
    parameter int HASH_WIDTH  = 32
)
(
    input  logic clk,
    input  logic rst_n,
    input  req_t req,
    input  cmd_t cmd,
    output sts_t sts,
    output rsp_t rsp,
    output logic done
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam bit POW2  = ((CAPACITY & (CAPACITY - 1)) == 0);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(CAPACITY - 1);

    // slot memory
    logic                   mem_valid [CAPACITY];
    logic [IDX_W-1:0]       mem_home  [CAPACITY];
    logic [HASH_WIDTH-1:0]  mem_hash  [CAPACITY];
    logic [KEY_WIDTH-1:0]   mem_key   [CAPACITY];
    logic [VALUE_WIDTH-1:0] mem_value [CAPACITY];

    logic                   rd_valid_reg;
    logic [IDX_W-1:0]       rd_home_reg;
    logic [HASH_WIDTH-1:0]  rd_hash_reg;
    logic [KEY_WIDTH-1:0]   rd_key_reg;
    logic [VALUE_WIDTH-1:0] rd_value_reg;

    logic [IDX_W-1:0]       rd_addr;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic                   wr_valid;
    logic [IDX_W-1:0]       wr_home;
    logic [HASH_WIDTH-1:0]  wr_hash;
    logic [KEY_WIDTH-1:0]   wr_key;
    logic [VALUE_WIDTH-1:0] wr_value;

    // request registers
    logic [63:0]            key_ext;
    logic [63:0]            hash_ext;
    logic [63:0]            value_ext;
    logic [63:0]            dflt_ext;
    logic [1:0]             type_reg;
    logic [KEY_WIDTH-1:0]   key_reg;
    logic [HASH_WIDTH-1:0]  hash_reg;
    logic [VALUE_WIDTH-1:0] value_reg;
    logic [VALUE_WIDTH-1:0] dflt_reg;
    logic [IDX_W-1:0]       home;
    logic                   mod_done;

    // walk state
    logic [IDX_W-1:0]       cur_reg;
    logic [IDX_W-1:0]       slot_reg;
    logic [IDX_W-1:0]       scan_reg;
    logic [CNT_W-1:0]       n_reg;
    logic [CNT_W-1:0]       iter_reg;
    logic                   hit_reg;
    logic                   none_reg;
    logic [VALUE_WIDTH-1:0] hold_value_reg;
    logic [IDX_W-1:0]       mv_home_reg;
    logic [HASH_WIDTH-1:0]  mv_hash_reg;
    logic [KEY_WIDTH-1:0]   mv_key_reg;
    logic [VALUE_WIDTH-1:0] mv_value_reg;

    logic [IDX_W-1:0]       clr_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    rsp_t                   rsp_reg;
    rsp_t                   rsp_next;
    logic                   done_reg;

    logic                   rd_match;

    function automatic logic [IDX_W-1:0] inc_idx(input logic [IDX_W-1:0] x);
        inc_idx = (x == LAST_IDX) ? '0 : x + 1'b1;
    endfunction

    assign key_ext   = 64'(req.key);
    assign hash_ext  = 64'(req.hash_word);
    assign value_ext = 64'(req.value);
    assign dflt_ext  = 64'(req.fallback_value);

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            type_reg  <= req.req_type;
            key_reg   <= key_ext[KEY_WIDTH-1:0];
            hash_reg  <= hash_ext[HASH_WIDTH-1:0];
            value_reg <= value_ext[VALUE_WIDTH-1:0];
            dflt_reg  <= dflt_ext[VALUE_WIDTH-1:0];
        end
    end

    // home slot: hash mod capacity
    generate
        if (POW2)
        begin : g_home_mask
            logic [63:0] hreg_ext;
            assign hreg_ext = 64'(hash_reg);
            assign home     = hreg_ext[IDX_W-1:0];
            assign mod_done = 1'b1;
        end
        else
        begin : g_home_recip
            localparam int NCH  = (HASH_WIDTH + 15) / 16;
            localparam int HP_W = NCH * 16;
            localparam int CC_W = $clog2(NCH + 1);
            localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(CAPACITY));
            localparam logic [31:0] CAP32 = 32'(CAPACITY);
            localparam logic [1:0]  PH_MUL = 2'd0;
            localparam logic [1:0]  PH_QC  = 2'd1;
            localparam logic [1:0]  PH_SUB = 2'd2;
            logic [HP_W-1:0]  shift_reg;
            logic [IDX_W-1:0] rem_reg;
            logic [CC_W-1:0]  ccnt_reg;
            logic [1:0]       ph_reg;
            logic [31:0]      t_reg;
            logic [63:0]      prod_reg;
            logic [31:0]      qc_reg;
            logic [31:0]      t_cur;
            logic [31:0]      diff;

            // horner over 16-bit chunks, reciprocal estimate is at most one low
            assign t_cur = {16'(rem_reg), shift_reg[HP_W-1 -: 16]};
            assign diff  = t_reg - qc_reg;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    ccnt_reg <= '0;
                    ph_reg   <= PH_MUL;
                end
                else if (cmd.load_req)
                begin
                    ccnt_reg <= CC_W'(NCH);
                    ph_reg   <= PH_MUL;
                end
                else if (ccnt_reg != '0)
                begin
                    if (ph_reg == PH_SUB)
                    begin
                        ph_reg   <= PH_MUL;
                        ccnt_reg <= ccnt_reg - 1'b1;
                    end
                    else
                    begin
                        ph_reg <= ph_reg + 1'b1;
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (cmd.load_req)
                begin
                    shift_reg <= hash_ext[HP_W-1:0];
                    rem_reg   <= '0;
                end
                else if (ccnt_reg != '0)
                begin
                    case (ph_reg)
                        PH_MUL:
                        begin
                            t_reg    <= t_cur;
                            prod_reg <= 64'(t_cur) * 64'(RECIP);
                        end
                        PH_QC:
                        begin
                            qc_reg <= prod_reg[63:32] * CAP32;
                        end
                        default:
                        begin
                            shift_reg <= shift_reg << 16;
                            if (diff >= CAP32)
                            begin
                                rem_reg <= IDX_W'(diff - CAP32);
                            end
                            else
                            begin
                                rem_reg <= diff[IDX_W-1:0];
                            end
                        end
                    endcase
                end
            end

            assign home     = rem_reg;
            assign mod_done = (ccnt_reg == '0);
        end
    endgenerate

    // read address
    always_comb
    begin
        case (cmd.rd_sel)
            RD_HOME_REQ:  rd_addr = home;
            RD_CUR_NEXT:  rd_addr = inc_idx(cur_reg);
            RD_SLOT_NEXT: rd_addr = inc_idx(slot_reg);
            RD_SCAN_NEXT: rd_addr = inc_idx(scan_reg);
            RD_MOVE_HOME: rd_addr = rd_home_reg;
            default:      rd_addr = cur_reg;
        endcase
    end

    // write port
    always_comb
    begin
        wr_en    = 1'b1;
        wr_addr  = cur_reg;
        wr_valid = 1'b0;
        wr_home  = home;
        wr_hash  = hash_reg;
        wr_key   = key_reg;
        wr_value = value_reg;
        case (cmd.wr_sel)
            WR_CLEAR:    wr_addr = clr_reg;
            WR_REQ:
            begin
                wr_addr  = slot_reg;
                wr_valid = 1'b1;
            end
            WR_DEL:      wr_addr = slot_reg;
            WR_SCAN_CLR: wr_addr = scan_reg;
            WR_MOVE:
            begin
                wr_addr  = cur_reg;
                wr_valid = 1'b1;
                wr_home  = mv_home_reg;
                wr_hash  = mv_hash_reg;
                wr_key   = mv_key_reg;
                wr_value = mv_value_reg;
            end
            default:     wr_en = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_valid[wr_addr] <= wr_valid;
            mem_home[wr_addr]  <= wr_home;
            mem_hash[wr_addr]  <= wr_hash;
            mem_key[wr_addr]   <= wr_key;
            mem_value[wr_addr] <= wr_value;
        end
        // write-first on a same-address collision
        if (wr_en && (wr_addr == rd_addr))
        begin
            rd_valid_reg <= wr_valid;
            rd_home_reg  <= wr_home;
            rd_hash_reg  <= wr_hash;
            rd_key_reg   <= wr_key;
            rd_value_reg <= wr_value;
        end
        else
        begin
            rd_valid_reg <= mem_valid[rd_addr];
            rd_home_reg  <= mem_home[rd_addr];
            rd_hash_reg  <= mem_hash[rd_addr];
            rd_key_reg   <= mem_key[rd_addr];
            rd_value_reg <= mem_value[rd_addr];
        end
    end

    assign rd_match = rd_valid_reg && (rd_hash_reg == hash_reg) && (rd_key_reg == key_reg);

    // walk pointers
    always_ff @(posedge clk)
    begin
        if ((cmd.rd_sel == RD_HOME_REQ) || (cmd.rd_sel == RD_CUR_NEXT) ||
            (cmd.rd_sel == RD_MOVE_HOME))
        begin
            cur_reg <= rd_addr;
        end
        if ((cmd.rd_sel == RD_SLOT_NEXT) || (cmd.rd_sel == RD_SCAN_NEXT))
        begin
            scan_reg <= rd_addr;
        end
        if (cmd.probe_start)
        begin
            n_reg <= '0;
        end
        else if (cmd.probe_adv)
        begin
            n_reg <= n_reg + 1'b1;
        end
        if (cmd.iter_clr)
        begin
            iter_reg <= '0;
        end
        else if (cmd.iter_inc)
        begin
            iter_reg <= iter_reg + 1'b1;
        end
        if (cmd.probe_stop)
        begin
            hit_reg        <= rd_match;
            none_reg       <= rd_valid_reg && !rd_match;
            slot_reg       <= cur_reg;
            hold_value_reg <= rd_value_reg;
        end
        if (cmd.mv_load)
        begin
            mv_home_reg  <= rd_home_reg;
            mv_hash_reg  <= rd_hash_reg;
            mv_key_reg   <= rd_key_reg;
            mv_value_reg <= rd_value_reg;
        end
        rsp_reg <= rsp_next;
    end

    // result of the request
    always_comb
    begin
        count_next           = count_reg;
        rsp_next.found       = hit_reg;
        rsp_next.read_value  = '0;
        rsp_next.status      = STATUS_OK;
        case (type_reg)
            REQ_GET:
            begin
                if (hit_reg)
                begin
                    rsp_next.read_value = 32'(hold_value_reg);
                end
            end
            REQ_GET_DEF:
            begin
                rsp_next.read_value = hit_reg ? 32'(hold_value_reg) : 32'(dflt_reg);
            end
            REQ_PUT:
            begin
                if (none_reg)
                begin
                    rsp_next.status = STATUS_FULL;
                end
                else if (!hit_reg)
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            default:
            begin
                if (hit_reg && (count_reg != '0))
                begin
                    count_next = count_reg - 1'b1;
                end
            end
        endcase
        rsp_next.entry_total = 9'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
            if (cmd.finish)
            begin
                count_reg <= count_next;
            end
            if (cmd.clr_inc)
            begin
                clr_reg <= inc_idx(clr_reg);
            end
        end
    end

    assign sts.clr_last   = (clr_reg == LAST_IDX);
    assign sts.mod_done   = mod_done;
    assign sts.rd_empty   = !rd_valid_reg;
    assign sts.rd_match   = rd_match;
    assign sts.rd_at_home = (rd_home_reg == scan_reg);
    assign sts.probe_last = (n_reg == LAST_CNT);
    assign sts.iter_last  = (iter_reg == LAST_CNT);
    assign sts.hit        = hit_reg;
    assign sts.none       = none_reg;
    assign sts.req_type   = type_reg;
    assign sts.count_gt1  = (count_reg > CNT_W'(1));

    assign rsp  = rsp_reg;
    assign done = done_reg;

endmodule

>>> src/lphm_checker.sv
// ----------------------------------------------------------------------------
// lphm_checker
// port-level checks on the hash map unit, bound to the top level
// ----------------------------------------------------------------------------
`include "linear_probe_hash_map_unit_defines.svh"

module lphm_checker
    import lphm_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input rsp_t rsp
);

    // one result per request, never back to back
    `LPHM_ASSERT_NEXT(a_done_single, clk, rst_n, done, !done, "done held two cycles")

    // a transfer marks the unit busy and gives no result in the next cycle
    `LPHM_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy && !done, "no busy after transfer")

    // a result follows a busy cycle
    `LPHM_ASSERT_SAME(a_done_after_busy, clk, rst_n, done, $past(busy), "done without busy")

    // full is only reported for a key that was absent
    `LPHM_ASSERT_SAME(a_full_miss, clk, rst_n, done && rsp.status, !rsp.found, "full on a hit")

endmodule

bind linear_probe_hash_map_unit lphm_checker u_lphm_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);
